### rtl/assert_macros.svh
// Assertion helpers used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, held off while reset is high.
`define ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/rgbaob_pkg.sv
`default_nettype none

package rgbaob_pkg;

  // Field widths.
  localparam int PixW   = 8;
  localparam int PosW   = 12;
  localparam int DimW   = 13;
  localparam int IdxW   = 2;
  localparam int ProdW  = 16;
  localparam int WideW  = 24;
  localparam int SumW   = 17;
  localparam int InW    = 88;
  localparam int OutW   = 32;

  // Largest frame dimension; register values above it act as it.
  localparam logic [DimW-1:0] MaxDim = 13'd4096;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] REG_OVERLAY_WIDTH  = 2'd0;
  localparam logic [IdxW-1:0] REG_OVERLAY_HEIGHT = 2'd1;
  localparam logic [IdxW-1:0] REG_KEEP_X         = 2'd2;
  localparam logic [IdxW-1:0] REG_KEEP_Y         = 2'd3;

  // One RGBA pixel; red sits in the lowest bits.
  typedef struct packed {
    logic [PixW-1:0] alpha;
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } pixel_t;

  // Saturates a written dimension at the frame limit.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    return (v > MaxDim) ? MaxDim : v;
  endfunction

  // First guess of x/255 from x * 0x01010101 / 2^32. The guess is the
  // true quotient or one below it.
  function automatic logic [ProdW-1:0] div255_est(input logic [WideW-1:0] x);
    logic [47:0] acc;
    acc = {x, 24'h0} + {8'h0, x, 16'h0} + {16'h0, x, 8'h0} + {24'h0, x};
    return acc[47:32];
  endfunction

  // Corrects the guess: one step up when the remainder reaches 255.
  function automatic logic [ProdW-1:0] div255_fix(input logic [WideW-1:0] x,
                                                  input logic [ProdW-1:0] q);
    logic [WideW:0] prod;
    logic [WideW:0] rem;
    prod = {1'b0, q, 8'h0} - {9'h0, q};
    rem  = {1'b0, x} - prod;
    return (rem >= 25'd255) ? q + 16'd1 : q;
  endfunction

endpackage

`default_nettype wire

### rtl/rgba_over_blend_with_keep_region.sv
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   column, row, base r/g/b/a, top r/g/b/a (88 bits)
// m_axis    out  out_red, out_green, out_blue, out_alpha (32 bits)
// cfg       in   cfg_wr_en, cfg_index, cfg_wr_data (13 bits)
//
// A pixel passes from input beat to output beat through six register stages,
// one pixel per cycle sustained while the output is not stalled (two multiply
// stages, then two two-step divide-by-255 units), each with its own valid bit.
// Synchronous reset clears the valid bits and the four registers to zero.
// A stalled output holds its beat; each stage still fills while the stage
// after it has room, so bubbles are squeezed out and nothing is lost.
`default_nettype none

`include "assert_macros.svh"

module rgba_over_blend_with_keep_region (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // column, row, base_red, base_green, base_blue, base_alpha,
  // top_red, top_green, top_blue, top_alpha
  input  wire logic [rgbaob_pkg::InW-1:0]  s_axis_tdata,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic      [rgbaob_pkg::OutW-1:0] m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic                        cfg_wr_en,
  input  wire logic [rgbaob_pkg::IdxW-1:0] cfg_index,
  input  wire logic [rgbaob_pkg::DimW-1:0] cfg_wr_data
);

  localparam int NumCh = 3;

  // Configuration registers.
  logic [rgbaob_pkg::DimW-1:0] overlay_width;
  logic [rgbaob_pkg::DimW-1:0] overlay_height;
  logic [rgbaob_pkg::DimW-1:0] keep_x;
  logic [rgbaob_pkg::DimW-1:0] keep_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      overlay_width  <= '0;
      overlay_height <= '0;
      keep_x         <= '0;
      keep_y         <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rgbaob_pkg::REG_OVERLAY_WIDTH:  overlay_width  <= rgbaob_pkg::clamp_dim(cfg_wr_data);
        rgbaob_pkg::REG_OVERLAY_HEIGHT: overlay_height <= rgbaob_pkg::clamp_dim(cfg_wr_data);
        rgbaob_pkg::REG_KEEP_X:         keep_x         <= rgbaob_pkg::clamp_dim(cfg_wr_data);
        rgbaob_pkg::REG_KEEP_Y:         keep_y         <= rgbaob_pkg::clamp_dim(cfg_wr_data);
        default: ;
      endcase
    end
  end

  // Input beat fields.
  logic [rgbaob_pkg::PosW-1:0] in_column;
  logic [rgbaob_pkg::PosW-1:0] in_row;
  rgbaob_pkg::pixel_t          in_base;
  rgbaob_pkg::pixel_t          in_top;

  assign in_column = s_axis_tdata[11:0];
  assign in_row    = s_axis_tdata[23:12];
  assign in_base   = s_axis_tdata[55:24];
  assign in_top    = s_axis_tdata[87:56];

  // Stage valid bits and load enables; a stage loads when it is empty or
  // the stage after it loads.
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6 || m_axis_tready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // Region test, written in full for clarity.
  logic in_keep;
  assign in_keep =
    (({1'b0, in_column} < keep_x) && ({1'b0, in_row} < keep_y)) ||
    ({1'b0, in_column} >= overlay_width) || ({1'b0, in_row} >= overlay_height);

  // Stage 1: region flag, top weight products and base weight.
  logic                         keep1;
  rgbaob_pkg::pixel_t           base1;
  logic [rgbaob_pkg::PixW-1:0]  ta1;
  logic [rgbaob_pkg::ProdW-1:0] tp1 [NumCh];
  logic [rgbaob_pkg::ProdW-1:0] ab255_1;
  logic [rgbaob_pkg::PixW-1:0]  top_c [NumCh];

  assign top_c[0] = in_top.red;
  assign top_c[1] = in_top.green;
  assign top_c[2] = in_top.blue;

  always_ff @(posedge clk) begin
    if (en1) begin
      keep1   <= in_keep;
      base1   <= in_base;
      ta1     <= in_top.alpha;
      ab255_1 <= {8'h0, in_base.alpha} * {8'h0, 8'd255 - in_top.alpha};
      for (int c = 0; c < NumCh; c++) begin
        tp1[c] <= {8'h0, in_top.alpha} * {8'h0, top_c[c]};
      end
    end
  end

  // Stage 2: base term products and the alpha quotient guess.
  logic                         keep2;
  rgbaob_pkg::pixel_t           base2;
  logic [rgbaob_pkg::PixW-1:0]  ta2;
  logic [rgbaob_pkg::ProdW-1:0] tp2 [NumCh];
  logic [rgbaob_pkg::WideW-1:0] p2 [NumCh];
  logic [rgbaob_pkg::ProdW-1:0] ab255_2;
  logic [rgbaob_pkg::ProdW-1:0] qa2;
  logic [rgbaob_pkg::PixW-1:0]  base_c1 [NumCh];

  assign base_c1[0] = base1.red;
  assign base_c1[1] = base1.green;
  assign base_c1[2] = base1.blue;

  always_ff @(posedge clk) begin
    if (en2) begin
      keep2   <= keep1;
      base2   <= base1;
      ta2     <= ta1;
      ab255_2 <= ab255_1;
      qa2     <= rgbaob_pkg::div255_est({8'h0, ab255_1});
      for (int c = 0; c < NumCh; c++) begin
        tp2[c] <= tp1[c];
        p2[c]  <= {8'h0, ab255_1} * {16'h0, base_c1[c]};
      end
    end
  end

  // Stage 3: final alpha, quotient guesses for the base terms.
  logic                         keep3;
  rgbaob_pkg::pixel_t           base3;
  logic [rgbaob_pkg::PixW-1:0]  alpha3;
  logic [rgbaob_pkg::ProdW-1:0] tp3 [NumCh];
  logic [rgbaob_pkg::WideW-1:0] p3 [NumCh];
  logic [rgbaob_pkg::ProdW-1:0] pq3 [NumCh];
  logic [rgbaob_pkg::ProdW-1:0] qa_fixed;

  assign qa_fixed = rgbaob_pkg::div255_fix({8'h0, ab255_2}, qa2);

  always_ff @(posedge clk) begin
    if (en3) begin
      keep3  <= keep2;
      base3  <= base2;
      alpha3 <= ta2 + qa_fixed[rgbaob_pkg::PixW-1:0];
      for (int c = 0; c < NumCh; c++) begin
        tp3[c] <= tp2[c];
        p3[c]  <= p2[c];
        pq3[c] <= rgbaob_pkg::div255_est(p2[c]);
      end
    end
  end

  // Stage 4: corrected base terms added to the top terms.
  logic                         keep4;
  rgbaob_pkg::pixel_t           base4;
  logic [rgbaob_pkg::PixW-1:0]  alpha4;
  logic [rgbaob_pkg::SumW-1:0]  sum4 [NumCh];
  logic [rgbaob_pkg::ProdW-1:0] pq_fixed [NumCh];

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      pq_fixed[c] = rgbaob_pkg::div255_fix(p3[c], pq3[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      keep4  <= keep3;
      base4  <= base3;
      alpha4 <= alpha3;
      for (int c = 0; c < NumCh; c++) begin
        sum4[c] <= {1'b0, tp3[c]} + {1'b0, pq_fixed[c]};
      end
    end
  end

  // Stage 5: quotient guesses for the channel sums.
  logic                         keep5;
  rgbaob_pkg::pixel_t           base5;
  logic [rgbaob_pkg::PixW-1:0]  alpha5;
  logic [rgbaob_pkg::SumW-1:0]  sum5 [NumCh];
  logic [rgbaob_pkg::ProdW-1:0] sq5 [NumCh];

  always_ff @(posedge clk) begin
    if (en5) begin
      keep5  <= keep4;
      base5  <= base4;
      alpha5 <= alpha4;
      for (int c = 0; c < NumCh; c++) begin
        sum5[c] <= sum4[c];
        sq5[c]  <= rgbaob_pkg::div255_est({7'h0, sum4[c]});
      end
    end
  end

  // Stage 6: corrected channels and the pass-through choice.
  rgbaob_pkg::pixel_t           out6;
  rgbaob_pkg::pixel_t           blend5;
  logic [rgbaob_pkg::ProdW-1:0] sq_fixed [NumCh];

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      sq_fixed[c] = rgbaob_pkg::div255_fix({7'h0, sum5[c]}, sq5[c]);
    end
    blend5.red   = sq_fixed[0][rgbaob_pkg::PixW-1:0];
    blend5.green = sq_fixed[1][rgbaob_pkg::PixW-1:0];
    blend5.blue  = sq_fixed[2][rgbaob_pkg::PixW-1:0];
    blend5.alpha = alpha5;
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out6 <= keep5 ? base5 : blend5;
    end
  end

  assign m_axis_tdata  = out6;
  assign m_axis_tvalid = v6;

  // A beat held in a stage that cannot move on stays there.
  `ASSERT_CLK(a_stage3_hold, clk, rst, v3 && !en4 |=> v3, "stage 3 beat dropped")
  // The input side is open whenever the first stage is empty.
  `ASSERT_CLK(a_ready_empty, clk, rst, !v1 |-> s_axis_tready, "ready low with empty stage")
  // Reset leaves no beat behind in the output stage.
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !m_axis_tvalid, "valid after reset")

endmodule

`default_nettype wire
